// ----- rtl/core/lidar_scan_two_char_decoder_defines.svh -----
// Assertion macros for the decoder's checker file.
`ifndef LIDAR_SCAN_TWO_CHAR_DECODER_DEFINES_SVH
`define LIDAR_SCAN_TWO_CHAR_DECODER_DEFINES_SVH

// Clocked assertion, muted while reset is held.
`define LSTCD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define LSTCD_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/lstcd_pkg.sv -----
// Types and constants of the two-character range decoder.
package lstcd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned DIST_W = 12;
	localparam int unsigned IDX_W  = 10;
	localparam int unsigned CFG_INDEX_W = 1;

	localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_BASE = 8'h30;
	localparam logic [BYTE_W-1:0] CH_TOP  = 8'h6F;
	localparam logic [BYTE_W-1:0] LINE_CNT_MAX = 8'hFF;

	localparam logic [DIST_W-1:0] MIN_DIST_RESET = 12'd66;
	localparam logic [DIST_W-1:0] MAX_DIST_RESET = 12'd2500;

	// register indexes on the configuration port
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_DISTANCE = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_DISTANCE = 1'd1;

	typedef enum logic [1:0] {
		PH_DONE   = 2'd0,
		PH_HEADER = 2'd1,
		PH_DATA   = 2'd2
	} phase_t;

	typedef struct packed {
		logic [DIST_W-1:0] min_distance;
		logic [DIST_W-1:0] max_distance;
	} cfg_t;

	typedef struct packed {
		logic              valid;
		logic [DIST_W-1:0] distance;
		logic [IDX_W-1:0]  sample_index;
		logic              last_sample;
	} result_t;

endpackage

// ----- rtl/core/lstcd_stream_if.sv -----
// Valid/ready channels for received bytes and decoded samples.
interface lstcd_byte_if;
	logic                             valid;
	logic                             ready;
	logic [lstcd_pkg::BYTE_W-1:0]     rx_byte;
	logic                             start_scan;

	modport source (output valid, output rx_byte, output start_scan, input ready);
	modport sink (input valid, input rx_byte, input start_scan, output ready);
endinterface

interface lstcd_sample_if;
	logic                             valid;
	logic                             ready;
	logic [lstcd_pkg::DIST_W-1:0]     distance;
	logic [lstcd_pkg::IDX_W-1:0]      sample_index;
	logic                             last_sample;

	modport source (output valid, output distance, output sample_index,
		output last_sample, input ready);
	modport sink (input valid, input distance, input sample_index,
		input last_sample, output ready);
endinterface

// ----- rtl/core/lstcd_cfg_regs.sv -----
// Distance window registers written through the configuration port.
module lstcd_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lstcd_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [lstcd_pkg::DIST_W-1:0]        cfg_wdata,
	output lstcd_pkg::cfg_t                     cfg
);

	lstcd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_distance <= lstcd_pkg::MIN_DIST_RESET;
			cfg_q.max_distance <= lstcd_pkg::MAX_DIST_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				lstcd_pkg::REG_MIN_DISTANCE: cfg_q.min_distance <= cfg_wdata;
				lstcd_pkg::REG_MAX_DISTANCE: cfg_q.max_distance <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/core/lstcd_parser.sv -----
// Reply parser: header line counting, character pairing and sample decode.
module lstcd_parser #(
	parameter int unsigned SAMPLES_PER_SCAN = 257,
	parameter int unsigned STAMP_LINE_CHARS = 5
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            step,       // consume the byte below
	input  logic [lstcd_pkg::BYTE_W-1:0]    rx_byte,
	input  logic                            start_scan,
	input  lstcd_pkg::cfg_t                 cfg,
	output lstcd_pkg::result_t              res
);

	localparam logic [lstcd_pkg::IDX_W:0]    SAMPLES   = (lstcd_pkg::IDX_W+1)'(SAMPLES_PER_SCAN);
	localparam logic [lstcd_pkg::BYTE_W-1:0] STAMP_LEN = lstcd_pkg::BYTE_W'(STAMP_LINE_CHARS);

	lstcd_pkg::phase_t                 phase_q, phase_eff, phase_d;
	logic [lstcd_pkg::BYTE_W-1:0]      line_cnt_q, line_cnt_eff, line_cnt_d;
	logic [lstcd_pkg::BYTE_W-1:0]      held_q, held_eff, held_d;
	logic                              half_q, half_eff, half_d;
	logic [lstcd_pkg::IDX_W-1:0]       cnt_q, cnt_eff, cnt_d;

	logic                              pair_has_lf;
	logic                              is_last;
	logic                              chars_ok;
	logic [lstcd_pkg::BYTE_W-1:0]      hi_off, lo_off;
	logic [lstcd_pkg::DIST_W-1:0]      raw_dist;

	// a start beat restarts the scan before its own byte is parsed
	always_comb begin
		if (start_scan) begin
			phase_eff    = lstcd_pkg::PH_HEADER;
			line_cnt_eff = '0;
			held_eff     = '0;
			half_eff     = 1'b0;
			cnt_eff      = '0;
		end else begin
			phase_eff    = phase_q;
			line_cnt_eff = line_cnt_q;
			held_eff     = held_q;
			half_eff     = half_q;
			cnt_eff      = cnt_q;
		end
	end

	assign pair_has_lf = (held_eff == lstcd_pkg::CH_LF) || (rx_byte == lstcd_pkg::CH_LF);
	assign is_last     = ({1'b0, cnt_eff} + 1'b1) >= SAMPLES;

	// next state
	always_comb begin
		phase_d    = phase_eff;
		line_cnt_d = line_cnt_eff;
		held_d     = held_eff;
		half_d     = half_eff;
		cnt_d      = cnt_eff;
		case (phase_eff)
			lstcd_pkg::PH_HEADER: begin
				if (rx_byte == lstcd_pkg::CH_LF) begin
					if (line_cnt_eff == STAMP_LEN) begin
						phase_d = lstcd_pkg::PH_DATA;
						half_d  = 1'b0;
						cnt_d   = '0;
					end
					line_cnt_d = '0;
				end else if (line_cnt_eff != lstcd_pkg::LINE_CNT_MAX) begin
					line_cnt_d = line_cnt_eff + 1'b1;
				end
			end
			lstcd_pkg::PH_DATA: begin
				if (!half_eff) begin
					held_d = rx_byte;
					half_d = 1'b1;
				end else begin
					half_d = 1'b0;
					if (!pair_has_lf) begin
						if (is_last) begin
							phase_d = lstcd_pkg::PH_DONE;
							cnt_d   = '0;
						end else begin
							cnt_d = cnt_eff + 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= lstcd_pkg::PH_DONE;
			line_cnt_q <= '0;
			held_q     <= '0;
			half_q     <= 1'b0;
			cnt_q      <= '0;
		end else if (step) begin
			phase_q    <= phase_d;
			line_cnt_q <= line_cnt_d;
			held_q     <= held_d;
			half_q     <= half_d;
			cnt_q      <= cnt_d;
		end
	end

	// outputs
	always_comb begin
		chars_ok = (held_eff >= lstcd_pkg::CH_BASE) && (held_eff <= lstcd_pkg::CH_TOP) &&
			(rx_byte >= lstcd_pkg::CH_BASE) && (rx_byte <= lstcd_pkg::CH_TOP);
		hi_off   = held_eff - lstcd_pkg::CH_BASE;
		lo_off   = rx_byte - lstcd_pkg::CH_BASE;
		raw_dist = {hi_off[5:0], lo_off[5:0]};

		res.valid        = (phase_eff == lstcd_pkg::PH_DATA) && half_eff && !pair_has_lf;
		res.sample_index = cnt_eff;
		res.last_sample  = is_last;
		if (chars_ok && (raw_dist >= cfg.min_distance) && (raw_dist <= cfg.max_distance)) begin
			res.distance = raw_dist;
		end else begin
			res.distance = '0;
		end
	end

endmodule

// ----- rtl/core/lidar_scan_two_char_decoder.sv -----
// Top level of the two-character range decoder.
//
//  channel     dir  beat payload                          handshake
//  byte_in     in   rx_byte[7:0], start_scan              valid/ready
//  sample_out  out  distance[11:0], sample_index[9:0],    valid/ready
//                   last_sample
//  cfg_*       in   cfg_index[0], cfg_wdata[11:0]          cfg_we strobe
//
// One byte a cycle sustained while sample_out takes its samples. A byte beat
// lands in the stage-one register; the parser consumes it once the output
// register is free, and any sample it yields goes to the output register.
// Reset clears the parse state to "done" (bytes ignored until start_scan)
// and loads the distance window 66..2500 mm. Backpressure: stage one only
// holds while an unread sample sits in the output register, so byte_in stays
// ready while the output slot drains in the same cycle.
module lidar_scan_two_char_decoder #(
	parameter int unsigned SAMPLES_PER_SCAN = 257,   // 1..1024
	parameter int unsigned STAMP_LINE_CHARS = 5      // 1..255
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lstcd_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [lstcd_pkg::DIST_W-1:0]        cfg_wdata,
	lstcd_byte_if.sink                          byte_in,
	lstcd_sample_if.source                      sample_out
);

	lstcd_pkg::cfg_t               cfg;
	lstcd_pkg::result_t            res;

	// stage one: the accepted byte beat
	logic                          valid_s1;
	logic [lstcd_pkg::BYTE_W-1:0]  rx_byte_s1;
	logic                          start_s1;

	// stage two: the sample handed out
	logic                          valid_s2;
	logic [lstcd_pkg::DIST_W-1:0]  distance_s2;
	logic [lstcd_pkg::IDX_W-1:0]   index_s2;
	logic                          last_s2;

	logic                          out_free;
	logic                          advance;

	assign out_free      = !valid_s2 || sample_out.ready;
	assign advance       = valid_s1 && out_free;
	assign byte_in.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			valid_s1 <= byte_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.valid && byte_in.ready) begin
			rx_byte_s1 <= byte_in.rx_byte;
			start_s1   <= byte_in.start_scan;
		end
	end

	lstcd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	lstcd_parser #(
		.SAMPLES_PER_SCAN (SAMPLES_PER_SCAN),
		.STAMP_LINE_CHARS (STAMP_LINE_CHARS)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.rx_byte    (rx_byte_s1),
		.start_scan (start_s1),
		.cfg        (cfg),
		.res        (res)
	);

	// output slot: refilled whenever it is free, emptied by a taken beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= advance && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			distance_s2 <= res.distance;
			index_s2    <= res.sample_index;
			last_s2     <= res.last_sample;
		end
	end

	assign sample_out.valid        = valid_s2;
	assign sample_out.distance     = distance_s2;
	assign sample_out.sample_index = index_s2;
	assign sample_out.last_sample  = last_s2;

endmodule

// ----- rtl/core/lstcd_checker.sv -----
// Port-level checker for the decoder, bound to the top level.
`include "lidar_scan_two_char_decoder_defines.svh"

module lstcd_checker #(
	parameter int unsigned SAMPLES_PER_SCAN = 257
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [lstcd_pkg::DIST_W-1:0]    distance,
	input logic [lstcd_pkg::IDX_W-1:0]     sample_index,
	input logic                            last_sample
);

	localparam logic [lstcd_pkg::IDX_W-1:0] LAST_IDX = lstcd_pkg::IDX_W'(SAMPLES_PER_SCAN - 1);

	logic in_beat;
	assign in_beat = in_valid && in_ready;

	`LSTCD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(distance) && $stable(sample_index) && $stable(last_sample), "stalled sample changed")

	`LSTCD_ASSERT(a_last_index, out_valid |-> (last_sample == (sample_index == LAST_IDX)), "last_sample does not match final index")

	`LSTCD_ASSERT(a_sample_cause, $rose(out_valid) |-> $past(in_beat, 2), "sample without a byte two edges earlier")

	`LSTCD_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !out_valid, "sample shown during reset")

endmodule

bind lidar_scan_two_char_decoder lstcd_checker #(
	.SAMPLES_PER_SCAN (SAMPLES_PER_SCAN)
) u_lstcd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (byte_in.valid),
	.in_ready     (byte_in.ready),
	.out_valid    (sample_out.valid),
	.out_ready    (sample_out.ready),
	.distance     (sample_out.distance),
	.sample_index (sample_out.sample_index),
	.last_sample  (sample_out.last_sample)
);
